// ===== hw/rtl/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class strict-priority queue:
// field widths, request and status codes, controller/datapath handshake.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // widths of the transaction fields
    localparam int TAG_W    = 32;
    localparam int TICKET_W = 16;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;   // capture request and read both queue heads
        logic exec;     // commit queue update and load the result register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy; // result register holds a transaction that is stalled
    } t_dp_status;

endpackage

// ===== hw/rtl/tcpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Request sequencer: takes one request, then commits it into the datapath
// as soon as the result register can take the new result.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tcpq_pkg::t_dp_status  i_status_dp,
    output tcpq_pkg::t_ctrl_cmd   o_cmd_ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_cmd_ctl.accept = 1'b0;
        o_cmd_ctl.exec   = 1'b0;
        n_state          = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd_ctl.accept = 1'b1;
                    n_state          = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait while the previous result is still stalled
                if (!i_status_dp.out_busy) begin
                    o_cmd_ctl.exec = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/tcpq_dp.sv =====
// ----------------------------------------------------------------------------
// tcpq_dp
// Datapath: two circular queue memories with head/tail pointers and fill
// counts, the wrapping ticket counter, and the result register.
// ----------------------------------------------------------------------------
module tcpq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 32,
    parameter int TICKET_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcpq_pkg::t_ctrl_cmd                 i_cmd_ctl,
    output tcpq_pkg::t_dp_status                o_status_dp,
    input  logic                                i_cmd,
    input  logic                                i_priority_req,
    input  logic [tcpq_pkg::TAG_W-1:0]          i_user_tag,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tcpq_pkg::TICKET_W-1:0]       o_ticket,
    output logic [tcpq_pkg::TAG_W-1:0]          o_served_tag,
    output logic                                o_served_priority,
    output logic [tcpq_pkg::STATUS_W-1:0]       o_status,
    output logic [tcpq_pkg::COUNT_W-1:0]        o_priority_count,
    output logic [tcpq_pkg::COUNT_W-1:0]        o_normal_count
);

    localparam int TW      = tcpq_pkg::TAG_W;
    localparam int TKW     = tcpq_pkg::TICKET_W;
    localparam int CW      = tcpq_pkg::COUNT_W;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int STAG_W  = (TAG_BITS < TW) ? TAG_BITS : TW;
    localparam int ENTRY_W = STAG_W + TICKET_BITS;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] f_adv(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    // queue memories, entry = {tag, ticket}
    logic [ENTRY_W-1:0]     r_p_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]     r_n_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]     r_p_rd;
    logic [ENTRY_W-1:0]     r_n_rd;

    logic [PTR_W-1:0]       r_p_head, r_p_tail, r_n_head, r_n_tail;
    logic [CNT_W-1:0]       r_p_fill, r_n_fill;
    logic [CNT_W-1:0]       n_p_fill, n_n_fill;
    logic [TICKET_BITS-1:0] r_ticket_cnt;
    logic [TICKET_BITS-1:0] n_ticket_cnt;

    // captured request
    logic                   r_req_cmd;
    logic                   r_req_prio;
    logic [STAG_W-1:0]      r_req_tag;

    // result register
    logic                   r_out_valid;
    logic [TKW-1:0]         r_ticket;
    logic [TW-1:0]          r_served_tag;
    logic                   r_served_prio;
    logic [1:0]             r_status;
    logic [CW-1:0]          r_p_count;
    logic [CW-1:0]          r_n_count;

    logic                   push_p, push_n, pop_p, pop_n;
    logic [TICKET_BITS-1:0] res_ticket;
    logic [STAG_W-1:0]      res_tag;
    logic                   res_prio;
    logic [1:0]             res_status;

    assign n_ticket_cnt = r_ticket_cnt + 1'b1;

    always_comb begin
        push_p     = 1'b0;
        push_n     = 1'b0;
        pop_p      = 1'b0;
        pop_n      = 1'b0;
        res_ticket = '0;
        res_tag    = '0;
        res_prio   = 1'b0;
        res_status = tcpq_pkg::ST_OK;
        if (r_req_cmd == tcpq_pkg::CMD_ENQ) begin
            if (r_req_prio ? (r_p_fill == FULL_CNT) : (r_n_fill == FULL_CNT)) begin
                res_status = tcpq_pkg::ST_FULL;
            end else begin
                push_p     = r_req_prio;
                push_n     = !r_req_prio;
                res_ticket = n_ticket_cnt;
            end
        end else begin
            // strict priority: the priority queue is always served first
            if (r_p_fill != '0) begin
                pop_p      = 1'b1;
                res_prio   = 1'b1;
                res_ticket = r_p_rd[TICKET_BITS-1:0];
                res_tag    = r_p_rd[ENTRY_W-1:TICKET_BITS];
            end else if (r_n_fill != '0) begin
                pop_n      = 1'b1;
                res_ticket = r_n_rd[TICKET_BITS-1:0];
                res_tag    = r_n_rd[ENTRY_W-1:TICKET_BITS];
            end else begin
                res_status = tcpq_pkg::ST_EMPTY;
            end
        end
    end

    always_comb begin
        n_p_fill = r_p_fill;
        n_n_fill = r_n_fill;
        if (push_p) begin
            n_p_fill = r_p_fill + 1'b1;
        end else if (pop_p) begin
            n_p_fill = r_p_fill - 1'b1;
        end
        if (push_n) begin
            n_n_fill = r_n_fill + 1'b1;
        end else if (pop_n) begin
            n_n_fill = r_n_fill - 1'b1;
        end
    end

    // memories and captured request, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept) begin
            r_req_cmd  <= i_cmd;
            r_req_prio <= i_priority_req;
            r_req_tag  <= i_user_tag[STAG_W-1:0];
            r_p_rd     <= r_p_mem[r_p_head];
            r_n_rd     <= r_n_mem[r_n_head];
        end
        if (i_cmd_ctl.exec && push_p) begin
            r_p_mem[r_p_tail] <= {r_req_tag, n_ticket_cnt};
        end
        if (i_cmd_ctl.exec && push_n) begin
            r_n_mem[r_n_tail] <= {r_req_tag, n_ticket_cnt};
        end
    end

    // queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_head     <= '0;
            r_p_tail     <= '0;
            r_n_head     <= '0;
            r_n_tail     <= '0;
            r_p_fill     <= '0;
            r_n_fill     <= '0;
            r_ticket_cnt <= '0;
        end else if (i_cmd_ctl.exec) begin
            r_p_fill <= n_p_fill;
            r_n_fill <= n_n_fill;
            if (push_p) begin
                r_p_tail <= f_adv(r_p_tail);
            end
            if (push_n) begin
                r_n_tail <= f_adv(r_n_tail);
            end
            if (pop_p) begin
                r_p_head <= f_adv(r_p_head);
            end
            if (pop_n) begin
                r_n_head <= f_adv(r_n_head);
            end
            if (push_p || push_n) begin
                r_ticket_cnt <= n_ticket_cnt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_ctl.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.exec) begin
            r_ticket      <= TKW'(res_ticket);
            r_served_tag  <= TW'(res_tag);
            r_served_prio <= res_prio;
            r_status      <= res_status;
            r_p_count     <= CW'(n_p_fill);
            r_n_count     <= CW'(n_n_fill);
        end
    end

    assign o_status_dp.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_ticket          = r_ticket;
    assign o_served_tag      = r_served_tag;
    assign o_served_priority = r_served_prio;
    assign o_status          = r_status;
    assign o_priority_count  = r_p_count;
    assign o_normal_count    = r_n_count;

endmodule

// ===== hw/rtl/two_class_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_queue_top
// Two FIFO queues, priority and normal, with strict-priority dequeue and a
// wrapping ticket counter; one result transaction per request transaction.
//
//   channel   direction   handshake                  payload
//   -------   ---------   ------------------------   -----------------------
//   request   in          i_in_valid / o_in_stall    cmd, priority_req, user_tag
//   result    out         o_out_valid / i_out_stall  ticket, tag, class, status, counts
//
// A request is accepted in the idle state, which captures it and reads both queue
// heads from the registered memory ports; the exec state then commits the update
// and loads the result register, waiting in that state while a result is stalled.
// A new request is accepted while a result still waits. Reset is synchronous
// and active low, and empties both queues.
// ----------------------------------------------------------------------------
module two_class_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 32,
    parameter int TICKET_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic                                i_priority_req,
    input  logic [tcpq_pkg::TAG_W-1:0]          i_user_tag,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tcpq_pkg::TICKET_W-1:0]       o_ticket,
    output logic [tcpq_pkg::TAG_W-1:0]          o_served_tag,
    output logic                                o_served_priority,
    output logic [tcpq_pkg::STATUS_W-1:0]       o_status,
    output logic [tcpq_pkg::COUNT_W-1:0]        o_priority_count,
    output logic [tcpq_pkg::COUNT_W-1:0]        o_normal_count
);

    tcpq_pkg::t_ctrl_cmd  cmd_ctl;
    tcpq_pkg::t_dp_status status_dp;

    tcpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_status_dp (status_dp),
        .o_cmd_ctl   (cmd_ctl)
    );

    tcpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .TICKET_BITS (TICKET_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_ctl         (cmd_ctl),
        .o_status_dp       (status_dp),
        .i_cmd             (i_cmd),
        .i_priority_req    (i_priority_req),
        .i_user_tag        (i_user_tag),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_ticket          (o_ticket),
        .o_served_tag      (o_served_tag),
        .o_served_priority (o_served_priority),
        .o_status          (o_status),
        .o_priority_count  (o_priority_count),
        .o_normal_count    (o_normal_count)
    );

endmodule
